FILE: hdl/bda_pkg.sv
`timescale 1ns / 1ps

package bda_pkg;

  localparam int PERIOD_BITS = 16;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_DATA_W  = 8;

  typedef logic [PERIOD_BITS-1:0] period_t;

  localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_LEVEL = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_REPEAT_START = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_REPEAT_STEP  = 2'd3;

  localparam logic [9:0]  RST_DEBOUNCE     = 10'd50;
  localparam logic [15:0] RST_REPEAT_START = 16'd500;
  localparam logic [15:0] RST_REPEAT_STEP  = 16'd50;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'b001,
    MODE_DEBOUNCE = 3'b010,
    MODE_PRESSED  = 3'b100
  } mode_t;

  typedef struct packed {
    logic        active_level;
    logic [9:0]  debounce_ticks;
    logic [15:0] repeat_start_ticks;
    logic [15:0] repeat_step_ticks;
  } cfg_t;

  typedef struct packed {
    logic held_level;
    logic release_pulse;
    logic repeat_pulse;
    logic click_pulse;
  } res_t;

endpackage

FILE: hdl/bda_cfg.sv
`timescale 1ns / 1ps

module bda_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bda_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [bda_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output bda_pkg::cfg_t                  cfg
);
  import bda_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_ACTIVE_LEVEL: cfg_nxt.active_level       = cfg_wdata[0];
        REG_DEBOUNCE:     cfg_nxt.debounce_ticks     = cfg_wdata[9:0];
        REG_REPEAT_START: cfg_nxt.repeat_start_ticks = cfg_wdata[15:0];
        REG_REPEAT_STEP:  cfg_nxt.repeat_step_ticks  = cfg_wdata[15:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_level       <= 1'b0;
      cfg_r.debounce_ticks     <= RST_DEBOUNCE;
      cfg_r.repeat_start_ticks <= RST_REPEAT_START;
      cfg_r.repeat_step_ticks  <= RST_REPEAT_STEP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hdl/bda_core.sv
`timescale 1ns / 1ps

module bda_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  logic          pin_level,
  input  bda_pkg::cfg_t cfg,
  output bda_pkg::res_t res
);
  import bda_pkg::*;

  mode_t   mode_r, mode_nxt;
  period_t cnt_r, cnt_nxt;
  period_t per_r, per_nxt;
  logic    held_r, held_nxt;

  logic        active;
  logic        expired;
  period_t     deb_p, start_p, step_p, per_less;
  logic [31:0] deb_ext, start_ext, step_ext;

  assign deb_ext   = {22'd0, cfg.debounce_ticks};
  assign start_ext = {16'd0, cfg.repeat_start_ticks};
  assign step_ext  = {16'd0, cfg.repeat_step_ticks};
  assign deb_p     = deb_ext[PERIOD_BITS-1:0];
  assign start_p   = start_ext[PERIOD_BITS-1:0];
  assign step_p    = step_ext[PERIOD_BITS-1:0];

  assign active   = (pin_level == cfg.active_level);
  assign expired  = (cnt_r <= period_t'(1));
  assign per_less = per_r - step_p;

  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    per_nxt  = per_r;
    held_nxt = held_r;
    res      = '0;
    case (mode_r)
      MODE_DEBOUNCE: begin
        if (expired) begin
          if (active) begin
            res.click_pulse = 1'b1;
            per_nxt  = start_p;
            cnt_nxt  = start_p;
            mode_nxt = MODE_PRESSED;
          end else begin
            cnt_nxt  = '0;
            mode_nxt = MODE_IDLE;
          end
        end else begin
          cnt_nxt = cnt_r - period_t'(1);
        end
      end
      MODE_PRESSED: begin
        if (!active) begin
          mode_nxt = MODE_IDLE;
          held_nxt = 1'b0;
          res.release_pulse = 1'b1;
          cnt_nxt  = '0;
        end else if (expired) begin
          held_nxt = 1'b1;
          res.click_pulse  = 1'b1;
          res.repeat_pulse = 1'b1;
          cnt_nxt = per_r;
          if (per_r >= step_p && per_less >= step_p) begin
            per_nxt = per_less;
          end else begin
            per_nxt = step_p;
          end
        end else begin
          cnt_nxt = cnt_r - period_t'(1);
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
        if (active) begin
          cnt_nxt  = deb_p;
          mode_nxt = MODE_DEBOUNCE;
        end
      end
    endcase
    res.held_level = held_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      cnt_r  <= '0;
      per_r  <= '0;
      held_r <= 1'b0;
    end else if (load) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      per_r  <= per_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

FILE: hdl/bda_outreg.sv
`timescale 1ns / 1ps

module bda_outreg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bda_pkg::res_t                  res,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [bda_pkg::OUT_DATA_W-1:0] out_data
);
  import bda_pkg::*;

  logic valid_r, valid_nxt;
  res_t data_r;
  logic load;

  assign in_ready  = !valid_r || out_ready;
  assign load      = in_valid && in_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = {{(OUT_DATA_W-4){1'b0}}, data_r};

endmodule

FILE: hdl/button_debounce_autorepeat_top.sv
`timescale 1ns / 1ps

// Button debouncer with accelerating auto-repeat. Feed one pin sample per
// millisecond tick; every input transaction yields exactly one output
// transaction carrying click, repeat and release pulses and the held level.
// One transaction per clock unless the output stalls: state update and result
// go combinationally into the output register, which decouples the sides, so
// results appear in the cycle after acceptance. Write registers through the
// cfg port only while no transaction is pending (the block does not enforce
// it); after reset active_level=0, debounce=50, repeat start=500, step=50 ticks.

module button_debounce_autorepeat_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [bda_pkg::IN_DATA_W-1:0]  in_tdata,   // [0] pin_level
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [bda_pkg::OUT_DATA_W-1:0] out_tdata,  // [0] click_pulse, [1] repeat_pulse,
                                                     // [2] release_pulse, [3] held_level
  input  logic                           cfg_we,
  input  logic [bda_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [bda_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bda_pkg::*;

  cfg_t cfg;
  res_t res;
  logic load;

  assign load = in_tvalid && in_tready;

  bda_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bda_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .pin_level (in_tdata[0]),
    .cfg       (cfg),
    .res       (res)
  );

  bda_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .res       (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

FILE: hdl/bda_checker.sv
`timescale 1ns / 1ps

module bda_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [bda_pkg::OUT_DATA_W-1:0] out_tdata
);
  import bda_pkg::*;

  // repeat only fires as a click while held
  a_repeat_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> out_tdata[0] && out_tdata[3])
    else $error("repeat without click or held");

  // release clears held and never coincides with a click
  a_release_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> !out_tdata[3] && !out_tdata[0])
    else $error("release with held or click");

  // held can only rise together with a repeat
  a_held_rise: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready ##1 out_tvalid && out_tdata[3] && !out_tdata[1]
      |-> $past(out_tdata[3]))
    else $error("held set without repeat");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

endmodule

bind button_debounce_autorepeat_top bda_checker u_bda_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
